FILE: hdl/rau_pkg.sv
// Shared widths, operation codes and sequencer states of the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	// magnitude products and their sums fit in twice the operand width
	localparam int NUM_W         = 2 * OPERAND_WIDTH;
	localparam int CNT_W         = $clog2(NUM_W + 1);
	localparam int RES_NUM_W     = 33;
	localparam int RES_DEN_W     = 32;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_D,
		ST_SUM,
		ST_GCD_TWO,
		ST_GCD_RUN,
		ST_DIV_NUM,
		ST_DIV_DEN,
		ST_FINISH
	} state_t;

endpackage

FILE: hdl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: fraction add/sub/mul/div with binary gcd reduction.
// Flow: an error item goes straight to the output step; otherwise ST_MUL_A, ST_MUL_B, ST_MUL_D
// and ST_SUM form the products and the sum, then twos stripping (a zero numerator skips to the
// output step), the binary gcd loop (one shift or compare-subtract per cycle), two divisions, output.
// Throughput: one item at a time; in_ready is high only while the sequencer idles.
// Reset (arst_n low) clears the sequencer and the output valid; an item in flight is dropped.
`timescale 1ns / 1ps

module rational_arithmetic_unit_top import rau_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cmd,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [RES_NUM_W-1:0] res_num,
	output logic [RES_DEN_W-1:0]        res_den,
	output logic                        error
);

	function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] x);
		mag_of = x[OPERAND_WIDTH-1] ? (~x + OPERAND_WIDTH'(1)) : x;
	endfunction

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   div_start;
	logic   out_load;

	cmd_t                   cmd_q;
	logic [OPERAND_WIDTH-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic                   an_s_q, ad_s_q, bn_s_q, bd_s_q;
	logic                   err_q, zero_q, neg_q;
	logic [NUM_W-1:0]       t1_q, t2_q, nm_q, dm_q, u_q, v_q, qn_q, qd_q;

	logic signed [RES_NUM_W-1:0] res_num_q;
	logic [RES_DEN_W-1:0]        res_den_q;
	logic                        error_q;

	logic [OPERAND_WIDTH-1:0] ma, mb;
	logic [NUM_W-1:0]         prod;
	logic                     s1, s2, sden, same, t1_ge, sum_neg, num_neg;
	logic [NUM_W-1:0]         opa, opb, sum_mag, num_mag;
	logic                     u_gt;
	logic [NUM_W-1:0]         big, little, diff;
	logic [NUM_W-1:0]         div_dividend;
	logic [NUM_W-1:0]         quotient;
	logic                     div_done;
	logic                     in_err;
	logic [RES_NUM_W-1:0]     nm_trunc;

	assign accept = in_valid && in_ready;
	assign in_err = (a_den == '0) || (b_den == '0) || ((cmd_t'(cmd) == CMD_DIV) && (b_num == '0));

	// shared magnitude multiplier
	always_comb begin
		case (state_q)
			ST_MUL_A: begin
				ma = an_m_q;
				mb = (cmd_q == CMD_MUL) ? bn_m_q : bd_m_q;
			end
			ST_MUL_B: begin
				ma = bn_m_q;
				mb = ad_m_q;
			end
			default: begin
				ma = ad_m_q;
				mb = (cmd_q == CMD_DIV) ? bn_m_q : bd_m_q;
			end
		endcase
	end
	assign prod = NUM_W'(ma) * NUM_W'(mb);

	// sign-magnitude combine of the two cross terms
	assign s1      = an_s_q ^ ((cmd_q == CMD_MUL) ? bn_s_q : bd_s_q);
	assign s2      = bn_s_q ^ ad_s_q ^ (cmd_q == CMD_SUB);
	assign sden    = ad_s_q ^ ((cmd_q == CMD_DIV) ? bn_s_q : bd_s_q);
	assign same    = (s1 == s2);
	assign t1_ge   = t1_q >= t2_q;
	assign opa     = (same || t1_ge) ? t1_q : t2_q;
	assign opb     = (same || t1_ge) ? t2_q : t1_q;
	assign sum_mag = same ? (opa + opb) : (opa - opb);
	assign sum_neg = (same || t1_ge) ? s1 : s2;
	assign num_mag = ((cmd_q == CMD_ADD) || (cmd_q == CMD_SUB)) ? sum_mag : t1_q;
	assign num_neg = ((cmd_q == CMD_ADD) || (cmd_q == CMD_SUB)) ? sum_neg : s1;

	// gcd compare-subtract
	assign u_gt   = u_q > v_q;
	assign big    = u_gt ? u_q : v_q;
	assign little = u_gt ? v_q : u_q;
	assign diff   = big - little;

	assign div_dividend = (state_q == ST_GCD_RUN) ? nm_q : dm_q;

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (u_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = in_err ? ST_FINISH : ST_MUL_A;
				end
			end
			ST_MUL_A: state_d = ST_MUL_B;
			ST_MUL_B: state_d = ST_MUL_D;
			ST_MUL_D: state_d = ST_SUM;
			ST_SUM:   state_d = ST_GCD_TWO;
			ST_GCD_TWO: begin
				if (nm_q == '0) begin
					state_d = ST_FINISH;
				end else if (nm_q[0] || dm_q[0]) begin
					state_d = ST_GCD_RUN;
				end
			end
			ST_GCD_RUN: begin
				if (v_q == '0) begin
					div_start = 1'b1;
					state_d   = ST_DIV_NUM;
				end
			end
			ST_DIV_NUM: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV_DEN;
				end
			end
			ST_DIV_DEN: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign nm_trunc = RES_NUM_W'(qn_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(cmd);
			an_m_q <= mag_of(a_num);
			ad_m_q <= mag_of(a_den);
			bn_m_q <= mag_of(b_num);
			bd_m_q <= mag_of(b_den);
			an_s_q <= a_num[OPERAND_WIDTH-1];
			ad_s_q <= a_den[OPERAND_WIDTH-1];
			bn_s_q <= b_num[OPERAND_WIDTH-1];
			bd_s_q <= b_den[OPERAND_WIDTH-1];
			err_q  <= in_err;
			zero_q <= 1'b0;
		end
		case (state_q)
			ST_MUL_A: t1_q <= prod;
			ST_MUL_B: t2_q <= prod;
			ST_MUL_D: dm_q <= prod;
			ST_SUM: begin
				nm_q  <= num_mag;
				neg_q <= num_neg ^ sden;
			end
			ST_GCD_TWO: begin
				// strip common factors of two from both values
				if (nm_q == '0) begin
					zero_q <= 1'b1;
				end else if (nm_q[0] || dm_q[0]) begin
					u_q <= nm_q;
					v_q <= dm_q;
				end else begin
					nm_q <= nm_q >> 1;
					dm_q <= dm_q >> 1;
				end
			end
			ST_GCD_RUN: begin
				if (v_q == '0) begin
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else begin
					if (u_gt) begin
						u_q <= v_q;
					end
					v_q <= diff;
				end
			end
			ST_DIV_NUM: begin
				if (div_done) begin
					qn_q <= quotient;
				end
			end
			ST_DIV_DEN: begin
				if (div_done) begin
					qd_q <= quotient;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			if (err_q) begin
				res_num_q <= '0;
				res_den_q <= '0;
				error_q   <= 1'b1;
			end else if (zero_q) begin
				res_num_q <= '0;
				res_den_q <= RES_DEN_W'(1);
				error_q   <= 1'b0;
			end else begin
				res_num_q <= neg_q ? -nm_trunc : nm_trunc;
				res_den_q <= RES_DEN_W'(qd_q);
				error_q   <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign error     = error_q;

endmodule

FILE: hdl/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rau_div import rau_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [NUM_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W:0]   shifted;
	logic [NUM_W:0]   trial;
	logic             fits;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, divisor};
	assign trial   = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the low bits hold it
			rem_q <= fits ? trial[NUM_W-1:0] : shifted[NUM_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: tb/sv/rational_arithmetic_unit_top_tb.sv
// Self-checking testbench for the rational arithmetic unit: fraction ops checked against a predictor.
`timescale 1ns / 1ps

module rational_arithmetic_unit_top_tb import rau_pkg::*; ();

	localparam int CLK_HALF         = 4;
	localparam int RESET_CYCLES     = 5;
	localparam int RANDOM_PER_PHASE = 280;
	localparam int HOLD_AT_ITEM     = 60;
	localparam int HOLD_CYCLES      = 1500;
	localparam int TAIL_CYCLES      = 400;
	localparam int CYCLE_LIMIT      = 2000000;
	localparam int MAX_REPORTS      = 10;

	typedef enum logic [1:0] {
		PH_SLOW_SINK,
		PH_SLOW_SOURCE,
		PH_STEADY
	} traffic_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [OPERAND_WIDTH-1:0] a_num;
		logic [OPERAND_WIDTH-1:0] a_den;
		logic [OPERAND_WIDTH-1:0] b_num;
		logic [OPERAND_WIDTH-1:0] b_den;
		traffic_t                 phase;
		logic                     drain_first;
	} fraction_op_t;

	typedef struct packed {
		logic [RES_NUM_W-1:0] num;
		logic [RES_DEN_W-1:0] den;
		logic                 err;
	} fraction_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic signed [OPERAND_WIDTH-1:0] a_num = '0;
	logic signed [OPERAND_WIDTH-1:0] a_den = '0;
	logic signed [OPERAND_WIDTH-1:0] b_num = '0;
	logic signed [OPERAND_WIDTH-1:0] b_den = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [RES_NUM_W-1:0] res_num;
	logic [RES_DEN_W-1:0] res_den;
	logic error;

	fraction_op_t pending_items[$];
	fraction_t    expected_results[$];
	fraction_t    want;
	fraction_op_t op;
	traffic_t     sink_phase = PH_SLOW_SINK;
	traffic_t     source_phase;
	logic         in_taken = 1'b0;
	logic         offer;
	logic         hold_done = 1'b0;
	int           hold_left = 0;
	int           accepted_count = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           send_idle_pct;
	int           ph, i;

	rational_arithmetic_unit_top dut (.*);

	always #CLK_HALF clk = ~clk;

	// exact reduced fraction; all products and sums fit easily in 64 bits
	function automatic fraction_t reduce_fraction(fraction_op_t x);
		longint an, ad, bn, bd, top, bottom, nm, dm, p, q, t;
		logic neg;
		fraction_t r;
		an = $signed(x.a_num);
		ad = $signed(x.a_den);
		bn = $signed(x.b_num);
		bd = $signed(x.b_den);
		r = '0;
		if (ad == 0 || bd == 0 || (x.cmd == CMD_DIV && bn == 0)) begin
			r.err = 1'b1;
			return r;
		end
		case (x.cmd)
			CMD_ADD: begin
				top = an * bd + bn * ad;
				bottom = ad * bd;
			end
			CMD_SUB: begin
				top = an * bd - bn * ad;
				bottom = ad * bd;
			end
			CMD_MUL: begin
				top = an * bn;
				bottom = ad * bd;
			end
			default: begin
				top = an * bd;
				bottom = ad * bn;
			end
		endcase
		if (top == 0) begin
			r.den = 1;
			return r;
		end
		neg = (top < 0) != (bottom < 0);
		nm = (top < 0) ? -top : top;
		dm = (bottom < 0) ? -bottom : bottom;
		p = nm;
		q = dm;
		while (q != 0) begin
			t = p % q;
			p = q;
			q = t;
		end
		r.num = neg ? -(nm / p) : (nm / p);
		r.den = dm / p;
		return r;
	endfunction

	// biased toward zero, extremes and small values so that reductions happen often
	function automatic logic [OPERAND_WIDTH-1:0] pick_operand();
		logic [OPERAND_WIDTH-1:0] v;
		case ($urandom_range(0, 19))
			0: v = '0;
			1, 2: begin
				case ($urandom_range(0, 3))
					0: v = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
					1: v = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
					2: v = '1;
					default: v = 1;
				endcase
			end
			3, 4, 5, 6, 7, 8: v = OPERAND_WIDTH'($urandom_range(0, 24)) - OPERAND_WIDTH'(12);
			9, 10, 11: begin
				v = OPERAND_WIDTH'($urandom_range(1, 255) << $urandom_range(0, 7));
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = OPERAND_WIDTH'($urandom);
		endcase
		return v;
	endfunction

	task automatic queue_op(cmd_t c, int an, int ad, int bn, int bd);
		fraction_op_t x;
		x.cmd = c;
		x.a_num = an[OPERAND_WIDTH-1:0];
		x.a_den = ad[OPERAND_WIDTH-1:0];
		x.b_num = bn[OPERAND_WIDTH-1:0];
		x.b_den = bd[OPERAND_WIDTH-1:0];
		x.phase = PH_SLOW_SINK;
		x.drain_first = 1'b0;
		pending_items.push_back(x);
	endtask

	// sender: presents the head of pending_items, never drops valid before acceptance
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			offer = pending_items.size() != 0;
			if (offer) begin
				source_phase = pending_items[0].phase;
				send_idle_pct = (source_phase == PH_SLOW_SINK) ? 9 :
					(source_phase == PH_SLOW_SOURCE) ? 85 : 0;
				if (pending_items[0].drain_first && expected_results.size() != 0)
					offer = 1'b0;
				else if ($urandom_range(0, 99) < send_idle_pct)
					offer = 1'b0;
			end
			in_valid <= offer;
			if (offer) begin
				cmd   <= pending_items[0].cmd;
				a_num <= pending_items[0].a_num;
				a_den <= pending_items[0].a_den;
				b_num <= pending_items[0].b_num;
				b_den <= pending_items[0].b_den;
			end
		end
	end

	// receiver: random stalls plus one long hold-off that backs the unit up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && accepted_count >= HOLD_AT_ITEM) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(0, 99) >= ((sink_phase == PH_SLOW_SINK) ? 85 :
					(sink_phase == PH_SLOW_SOURCE) ? 9 : 0);
			end
		end
	end

	// input acceptance, prediction and result checking
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			expected_results.push_back(reduce_fraction(pending_items[0]));
			sink_phase = pending_items[0].phase;
			pending_items.pop_front();
			accepted_count++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result %0d/%0d err %0b", res_num, res_den, error);
			end else begin
				want = expected_results.pop_front();
				if (res_num !== want.num || res_den !== want.den || error !== want.err) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: got %0d/%0d err %0b, expected %0d/%0d err %0b",
							res_num, res_den, error, $signed(want.num), want.den, want.err);
				end
			end
		end
	end

	initial begin
		// directed: basic ops, zero numerators, zero denominators, division by zero,
		// equal denominators, sign normalization and extreme operands
		queue_op(CMD_ADD, 1, 2, 1, 3);
		queue_op(CMD_SUB, 1, 2, 1, 2);
		queue_op(CMD_MUL, 0, 5, 3, 7);
		queue_op(CMD_DIV, 1, 2, 0, 3);
		queue_op(CMD_DIV, 0, 2, 0, 3);
		queue_op(CMD_ADD, 1, 0, 1, 3);
		queue_op(CMD_SUB, 1, 2, 1, 0);
		queue_op(CMD_MUL, 5, 0, 7, 0);
		queue_op(CMD_ADD, 1, 4, 1, 4);
		queue_op(CMD_SUB, 3, 8, 1, 8);
		queue_op(CMD_MUL, 1, -3, 2, 1);
		queue_op(CMD_DIV, 3, 4, -9, 8);
		queue_op(CMD_MUL, -32768, 1, -32768, 1);
		queue_op(CMD_ADD, -32768, -32767, -32768, 32767);
		queue_op(CMD_ADD, -32768, 32767, -32768, 32765);
		queue_op(CMD_SUB, 32767, -32768, -32768, 32767);
		queue_op(CMD_DIV, -32768, 1, 1, -32768);
		queue_op(CMD_DIV, 32767, -32768, -32768, 32767);
		queue_op(CMD_MUL, 32767, 32767, -1, -1);
		queue_op(CMD_SUB, -32768, 1, 32767, 1);
		queue_op(CMD_ADD, -32768, -32768, -32768, -32767);
		queue_op(CMD_DIV, -1, -1, -1, -1);
		// random phases; each starts once every earlier result is back
		for (ph = 0; ph < 3; ph++) begin
			for (i = 0; i < RANDOM_PER_PHASE; i++) begin
				op.cmd = cmd_t'($urandom_range(0, 3));
				op.a_num = pick_operand();
				op.a_den = pick_operand();
				op.b_num = pick_operand();
				op.b_den = pick_operand();
				op.phase = traffic_t'(ph);
				op.drain_first = (i == 0);
				pending_items.push_back(op);
			end
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (pending_items.size() != 0 || expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
